@@ hdl/zlhp_pkg.sv @@
`timescale 1ns / 1ps

package zlhp_pkg;

	// Signatures, little-endian as they arrive on the wire
	localparam logic [31:0] HDR_SIG = 32'h04034b50;
	localparam logic [31:0] DD_SIG  = 32'h08074b50;

	localparam int HDR_LEN     = 30;   // local file header bytes
	localparam int SIG_LAST    = 3;    // offset of the last signature byte
	localparam int FLAG_OFS    = 6;    // low byte of the flag word
	localparam int FLAG_DD_BIT = 3;    // data descriptor present
	localparam int DD_AT       = 14;   // crc / sizes offset in the header
	localparam int DD_LEN      = 12;   // descriptor bytes after its signature
	localparam int DD_BYTES    = 16;   // signature plus descriptor fields
	localparam int SCAN_FULL   = 4;    // window holds a whole word

	localparam int CNT_W = 5;
	localparam int IDX_W = $clog2(HDR_LEN);

	localparam int OUTQ_DEPTH = 3;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam int TDATA_W = 216;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SCAN,
		PH_CAPTURE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BADSIG,
		ST_NODD,
		ST_TRUNC
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  descriptor_bytes;
		logic [15:0] extra_length;
		logic [15:0] name_length;
		logic [31:0] plain_size;
		logic [31:0] packed_size;
		logic [31:0] crc_value;
		logic [15:0] mod_date;
		logic [15:0] mod_time;
		logic [15:0] method;
		logic [15:0] purpose_flags;
		logic [15:0] version_needed;
	} zlhp_result_t;

endpackage

@@ hdl/zip_local_header_parser.sv @@
`timescale 1ns / 1ps
// Zip local file header parser, one archive byte per transfer.
// Throughput: one byte per cycle, back to back, as long as results drain.
// A result passes from the byte in the input register through the parser logic
// into the result queue, which drives m_axis.
// Reset (arst_n low, asynchronous): parser back to header phase, queue emptied.
module zip_local_header_parser
	import zlhp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input byte stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  logic               s_axis_tlast,   // last byte of the stream
	// parsed header results
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [15:0] version_needed, [31:16] purpose_flags, [47:32] method,
	// [63:48] mod_time, [79:64] mod_date, [111:80] crc_value,
	// [143:112] packed_size, [175:144] plain_size, [191:176] name_length,
	// [207:192] extra_length, [212:208] descriptor_bytes, [215:213] zero
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]         m_axis_tuser    // [1:0] status
);

	logic                  in_xfer;
	logic                  core_pending;
	logic                  res_valid;
	zlhp_result_t          res;
	zlhp_result_t          q_data;
	logic [OUTQ_CNT_W-1:0] q_level;
	logic [OUTQ_CNT_W:0]   claimed;

	// Every byte in the input register may still yield a result, so it
	// holds a queue slot. With three slots and a draining sink the input
	// side never stalls; ready comes from registers only, so there is no
	// combinational path from m_axis_tready to s_axis_tready.
	assign claimed       = {1'b0, q_level} + {{OUTQ_CNT_W{1'b0}}, core_pending};
	assign s_axis_tready = (claimed < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Header phase collects the 30 header bytes, scan phase slides a word
	// window looking for the descriptor signature, capture phase takes the
	// 12 descriptor bytes; after a result bytes are dropped until tlast.
	zlhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_xfer),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.pending   (core_pending),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: a small queue parts the two handshakes.
	zlhp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (q_data),
		.level     (q_level)
	);

	assign m_axis_tuser = q_data.status;
	assign m_axis_tdata = {
		3'b000,
		q_data.descriptor_bytes,
		q_data.extra_length,
		q_data.name_length,
		q_data.plain_size,
		q_data.packed_size,
		q_data.crc_value,
		q_data.mod_date,
		q_data.mod_time,
		q_data.method,
		q_data.purpose_flags,
		q_data.version_needed
	};

endmodule

@@ hdl/zlhp_core.sv @@
`timescale 1ns / 1ps

module zlhp_core
	import zlhp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   in_byte,
	input  logic         in_last,
	output logic         pending,
	output logic         res_valid,
	output zlhp_result_t res
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      window_q, window_d;
	logic [7:0]       hdr_q [HDR_LEN];
	logic [7:0]       hdr_d [HDR_LEN];

	logic             wr_en;
	logic [CNT_W-1:0] wr_idx;
	logic [31:0]      win_shift;
	logic             res_any;
	status_t          res_status;
	logic             res_dd;
	logic             match;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			window_q <= '0;
		end else begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			window_q <= window_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q <= hdr_d;
	end

	assign win_shift = {byte_s1, window_q[31:8]};

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		window_d   = window_q;
		wr_en      = 1'b0;
		wr_idx     = count_q;
		res_any    = 1'b0;
		res_status = ST_OK;
		res_dd     = 1'b0;
		match      = 1'b0;
		if (valid_s1) begin
			unique case (phase_q)
				PH_HEADER: begin
					wr_en    = 1'b1;
					wr_idx   = count_q;
					window_d = win_shift;
					count_d  = count_q + CNT_W'(1);
					if (count_q == CNT_W'(SIG_LAST) && win_shift != HDR_SIG) begin
						res_any    = 1'b1;
						res_status = ST_BADSIG;
					end else if (count_q == CNT_W'(HDR_LEN - 1)) begin
						if (hdr_q[FLAG_OFS][FLAG_DD_BIT]) begin
							phase_d  = PH_SCAN;
							count_d  = '0;
							window_d = '0;
							if (last_s1) begin
								res_any    = 1'b1;
								res_status = ST_NODD;
							end
						end else begin
							res_any    = 1'b1;
							res_status = ST_OK;
						end
					end else if (last_s1) begin
						res_any    = 1'b1;
						res_status = ST_TRUNC;
					end
				end
				PH_SCAN: begin
					window_d = win_shift;
					if (count_q < CNT_W'(SCAN_FULL)) begin
						count_d = count_q + CNT_W'(1);
					end
					match = (count_d >= CNT_W'(SCAN_FULL)) && (win_shift == DD_SIG);
					if (match) begin
						if (last_s1) begin
							res_any    = 1'b1;
							res_status = ST_TRUNC;
						end else begin
							phase_d = PH_CAPTURE;
							count_d = '0;
						end
					end else if (last_s1) begin
						res_any    = 1'b1;
						res_status = ST_NODD;
					end
				end
				PH_CAPTURE: begin
					wr_en   = (count_q < CNT_W'(DD_LEN));
					wr_idx  = CNT_W'(DD_AT) + count_q;
					count_d = count_q + CNT_W'(1);
					if (count_q >= CNT_W'(DD_LEN - 1)) begin
						res_any    = 1'b1;
						res_status = ST_OK;
						res_dd     = 1'b1;
					end else if (last_s1) begin
						res_any    = 1'b1;
						res_status = ST_TRUNC;
					end
				end
				default: begin
					// done, and unused codes: wait for the end of the stream
					if (last_s1) begin
						phase_d  = PH_HEADER;
						count_d  = '0;
						window_d = '0;
					end
				end
			endcase
			if (res_any) begin
				if (last_s1) begin
					phase_d  = PH_HEADER;
					count_d  = '0;
					window_d = '0;
				end else begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	// header bytes with this cycle's write merged in, so the final byte counts
	always_comb begin
		hdr_d = hdr_q;
		if (wr_en && wr_idx < CNT_W'(HDR_LEN)) begin
			hdr_d[wr_idx[IDX_W-1:0]] = byte_s1;
		end
	end

	always_comb begin
		res = '0;
		res.status = res_status;
		if (res_status == ST_OK || res_status == ST_NODD) begin
			res.version_needed   = {hdr_d[5], hdr_d[4]};
			res.purpose_flags    = {hdr_d[7], hdr_d[6]};
			res.method           = {hdr_d[9], hdr_d[8]};
			res.mod_time         = {hdr_d[11], hdr_d[10]};
			res.mod_date         = {hdr_d[13], hdr_d[12]};
			res.crc_value        = {hdr_d[17], hdr_d[16], hdr_d[15], hdr_d[14]};
			res.packed_size      = {hdr_d[21], hdr_d[20], hdr_d[19], hdr_d[18]};
			res.plain_size       = {hdr_d[25], hdr_d[24], hdr_d[23], hdr_d[22]};
			res.name_length      = {hdr_d[27], hdr_d[26]};
			res.extra_length     = {hdr_d[29], hdr_d[28]};
			res.descriptor_bytes = res_dd ? 5'(DD_BYTES) : 5'd0;
		end
	end

	assign res_valid = res_any;
	assign pending   = valid_s1;

`ifndef SYNTHESIS
	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> count_q < CNT_W'(HDR_LEN))
		else $error("header byte count past header length");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SCAN |-> count_q <= CNT_W'(SCAN_FULL))
		else $error("scan count not saturated");

	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CAPTURE |-> count_q < CNT_W'(DD_LEN))
		else $error("descriptor capture overran");

	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last_s1) |=> phase_q == PH_DONE)
		else $error("result without moving to done");
`endif

endmodule

@@ hdl/zlhp_outq.sv @@
`timescale 1ns / 1ps

module zlhp_outq
	import zlhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  zlhp_result_t          push_data,
	input  logic                  pop_ready,
	output logic                  out_valid,
	output zlhp_result_t          out_data,
	output logic [OUTQ_CNT_W-1:0] level
);

	zlhp_result_t          mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && pop_ready;
	assign out_data  = mem[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
				          : wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
				          : rd_ptr_q + OUTQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OUTQ_CNT_W'(1);
				2'b01:   count_q <= count_q - OUTQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> count_q != OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");
`endif

endmodule

@@ test/zlhp_header_checker.sv @@
`timescale 1ns / 1ps
// Watches both streams, tracks the header parse byte by byte and checks
// every parsed header result against the oldest one predicted.
module zlhp_header_checker
	import zlhp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic [1:0]         m_tuser,
	output int                 mismatches,
	output int                 pending
);

	phase_t      ph;
	logic [4:0]  cnt;
	logic [31:0] window;
	logic [7:0]  hdr_bytes [0:31];
	int          errs = 0;

	zlhp_result_t expected_headers [$];

	task automatic clear_parser();
		ph = PH_HEADER;
		cnt = '0;
		window = '0;
		for (int i = 0; i < 32; i++)
			hdr_bytes[i] = 8'h00;
	endtask

	function automatic zlhp_result_t build_result(input status_t st, input bit with_dd);
		zlhp_result_t r;
		r = '0;
		r.status = st;
		// header words only survive on ok and no-descriptor results
		if (st == ST_OK || st == ST_NODD) begin
			r.version_needed   = {hdr_bytes[5], hdr_bytes[4]};
			r.purpose_flags    = {hdr_bytes[7], hdr_bytes[6]};
			r.method           = {hdr_bytes[9], hdr_bytes[8]};
			r.mod_time         = {hdr_bytes[11], hdr_bytes[10]};
			r.mod_date         = {hdr_bytes[13], hdr_bytes[12]};
			r.crc_value        = {hdr_bytes[17], hdr_bytes[16], hdr_bytes[15], hdr_bytes[14]};
			r.packed_size      = {hdr_bytes[21], hdr_bytes[20], hdr_bytes[19], hdr_bytes[18]};
			r.plain_size       = {hdr_bytes[25], hdr_bytes[24], hdr_bytes[23], hdr_bytes[22]};
			r.name_length      = {hdr_bytes[27], hdr_bytes[26]};
			r.extra_length     = {hdr_bytes[29], hdr_bytes[28]};
			r.descriptor_bytes = with_dd ? 5'(DD_BYTES) : 5'd0;
		end
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic l);
		bit         has_result;
		bit         with_dd;
		status_t    st;
		logic [4:0] c;
		has_result = 0;
		with_dd = 0;
		st = ST_OK;
		if (ph == PH_HEADER) begin
			c = cnt;
			hdr_bytes[c] = b;
			window = {b, window[31:8]};
			cnt = c + 5'd1;
			if (c == SIG_LAST && window != HDR_SIG) begin
				has_result = 1;
				st = ST_BADSIG;
			end else if (c == HDR_LEN - 1) begin
				if (hdr_bytes[FLAG_OFS][FLAG_DD_BIT]) begin
					ph = PH_SCAN;
					cnt = '0;
					window = '0;
					if (l) begin
						has_result = 1;
						st = ST_NODD;
					end
				end else begin
					has_result = 1;
					st = ST_OK;
				end
			end else if (l) begin
				has_result = 1;
				st = ST_TRUNC;
			end
		end else if (ph == PH_SCAN) begin
			window = {b, window[31:8]};
			if (cnt < SCAN_FULL)
				cnt = cnt + 5'd1;
			if (cnt >= SCAN_FULL && window == DD_SIG) begin
				if (l) begin
					has_result = 1;
					st = ST_TRUNC;
				end else begin
					ph = PH_CAPTURE;
					cnt = '0;
				end
			end else if (l) begin
				has_result = 1;
				st = ST_NODD;
			end
		end else if (ph == PH_CAPTURE) begin
			c = cnt;
			if (c < DD_LEN)
				hdr_bytes[DD_AT + c] = b;
			cnt = c + 5'd1;
			if (c + 1 >= DD_LEN) begin
				has_result = 1;
				st = ST_OK;
				with_dd = 1;
			end else if (l) begin
				has_result = 1;
				st = ST_TRUNC;
			end
		end else begin
			// done: skip to the end of the stream
			if (l)
				clear_parser();
			return;
		end
		if (has_result) begin
			expected_headers.push_back(build_result(st, with_dd));
			if (l)
				clear_parser();
			else
				ph = PH_DONE;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errs++;
		end
	endtask

	task automatic compare_result();
		zlhp_result_t want;
		if (expected_headers.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0d tdata %0h",
				$time, m_tuser, m_tdata);
			errs++;
			return;
		end
		want = expected_headers.pop_front();
		check_field("status", 32'(want.status), 32'(m_tuser));
		check_field("version_needed", 32'(want.version_needed), 32'(m_tdata[15:0]));
		check_field("purpose_flags", 32'(want.purpose_flags), 32'(m_tdata[31:16]));
		check_field("method", 32'(want.method), 32'(m_tdata[47:32]));
		check_field("mod_time", 32'(want.mod_time), 32'(m_tdata[63:48]));
		check_field("mod_date", 32'(want.mod_date), 32'(m_tdata[79:64]));
		check_field("crc_value", want.crc_value, m_tdata[111:80]);
		check_field("packed_size", want.packed_size, m_tdata[143:112]);
		check_field("plain_size", want.plain_size, m_tdata[175:144]);
		check_field("name_length", 32'(want.name_length), 32'(m_tdata[191:176]));
		check_field("extra_length", 32'(want.extra_length), 32'(m_tdata[207:192]));
		check_field("descriptor_bytes", 32'(want.descriptor_bytes), 32'(m_tdata[212:208]));
	endtask

	// output first: a result never comes from the byte taken on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_headers.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_result();
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			pending <= expected_headers.size();
			mismatches <= errs;
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the header parser test. Builds archive streams (good headers with
// and without data descriptors, bad signatures, streams cut short at every
// stage, plain noise), sends them a byte per transfer and lets the checker
// predict and compare. Both sides idle in random bursts, the receiver holds
// off once for a long stretch so the result queue fills and stalls input.
module tb;
	import zlhp_pkg::*;

	localparam int ITEMS       = 1000;  // bytes sent before the random part stops
	localparam int MIN_STREAMS = 48;    // keep going until this many streams sent
	localparam int HOLD_CYCLES = 300;   // receiver back-pressure stretch
	localparam int SETTLE      = 16;    // cycles after the last expectation
	localparam int LIMIT       = 4000;  // cycles with no transfer at all

	// header body fill
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	typedef enum int {
		K_PLAIN,        // header without descriptor, trailing bytes
		K_DESCRIPTOR,   // descriptor found, all 12 bytes captured
		K_NO_DESC,      // flag set, stream ends before the signature
		K_CUT_CAPTURE,  // stream ends on the match or inside the descriptor
		K_BAD_SIG,      // wrong signature, trailing bytes
		K_CUT_HEADER,   // stream ends inside the header
		K_NOISE         // arbitrary bytes
	} stream_kind_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [1:0]         m_axis_tuser;

	int mismatches;
	int pending;

	logic [7:0] stream_q [$];
	int         bytes_sent   = 0;
	int         streams_sent = 0;
	int         gap_odds     = 0;  // 0: no sender gaps in this stream
	bit         quiet        = 0;  // final part: no idling on either side
	bit         hold_req     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	zip_local_header_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	zlhp_header_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tlast    (s_axis_tlast),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Header field bytes lean toward the extremes.
	function automatic logic [7:0] field_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			stream_q.push_back(w[8*i +: 8]);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			stream_q.push_back(8'($urandom()));
	endtask

	// Bytes between header and descriptor; sometimes a partial signature
	// sneaks in to exercise the sliding window.
	task automatic push_scan_filler(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				for (int k = 0; k < $urandom_range(1, 3); k++)
					stream_q.push_back(DD_SIG[8*k +: 8]);
			end else begin
				stream_q.push_back(8'($urandom()));
			end
		end
	endtask

	task automatic push_header(input bit dd_flag, input int fill);
		logic [7:0] b;
		push_word(HDR_SIG);
		for (int i = 4; i < HDR_LEN; i++) begin
			b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : field_byte();
			if (i == FLAG_OFS)
				b[FLAG_DD_BIT] = dd_flag;
			stream_q.push_back(b);
		end
	endtask

	function automatic logic [31:0] bad_signature();
		logic [31:0] w;
		w = $urandom();
		if (w == HDR_SIG)
			w[0] = ~w[0];
		return w;
	endfunction

	// One byte per transfer; tvalid only ever gets one update per step.
	task automatic send_byte(input logic [7:0] b, input logic l);
		if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
		stream_q.delete();
		streams_sent++;
	endtask

	task automatic make_random_stream();
		stream_kind_t kind;
		int           n;
		int           pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)      kind = K_PLAIN;
		else if (pick < 50) kind = K_DESCRIPTOR;
		else if (pick < 60) kind = K_NO_DESC;
		else if (pick < 70) kind = K_CUT_CAPTURE;
		else if (pick < 80) kind = K_BAD_SIG;
		else if (pick < 92) kind = K_CUT_HEADER;
		else                kind = K_NOISE;
		case (kind)
			K_PLAIN: begin
				push_header(1'b0, FILL_RANDOM);
				push_random($urandom_range(0, 6));
			end
			K_DESCRIPTOR: begin
				push_header(1'b1, FILL_RANDOM);
				push_scan_filler($urandom_range(0, 10));
				push_word(DD_SIG);
				for (int i = 0; i < DD_LEN; i++)
					stream_q.push_back(field_byte());
				push_random($urandom_range(0, 4));
			end
			K_NO_DESC: begin
				push_header(1'b1, FILL_RANDOM);
				push_scan_filler($urandom_range(0, 10));
			end
			K_CUT_CAPTURE: begin
				push_header(1'b1, FILL_RANDOM);
				push_scan_filler($urandom_range(0, 6));
				push_word(DD_SIG);
				push_random($urandom_range(0, DD_LEN - 1));
			end
			K_BAD_SIG: begin
				push_word(bad_signature());
				push_random($urandom_range(0, 8));
			end
			K_CUT_HEADER: begin
				push_header($urandom_range(0, 1), FILL_RANDOM);
				n = $urandom_range(1, HDR_LEN - 1);
				stream_q = stream_q[0:n-1];
			end
			default: push_random($urandom_range(1, 40));
		endcase
	endtask

	// Receiver: random stall bursts, one long hold on request, none at the end.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any transfer on either stream.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("zip_local_header_parser test failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: short cut-offs first, then full headers at the extremes.
		push_word(32'h00000000);             // bad signature, last on its fourth byte
		send_stream();
		stream_q.push_back(8'hFF);           // stream of a single byte
		send_stream();
		push_word(HDR_SIG);                  // good signature, then end of stream
		send_stream();
		push_header(1'b0, FILL_ONES);        // all-ones fields, last on final header byte
		send_stream();
		push_header(1'b1, FILL_ZERO);        // flag set, last on final header byte
		send_stream();
		push_header(1'b1, FILL_ZERO);        // descriptor right away, last on its twelfth byte
		push_word(DD_SIG);
		for (int i = 0; i < DD_LEN; i++)
			stream_q.push_back(8'hFF);
		send_stream();
		push_header(1'b1, FILL_ONES);        // match on the last byte
		push_word(DD_SIG);
		send_stream();
		push_word(32'hFFFFFFFF);             // bad signature, trailing bytes ignored
		push_random(3);
		send_stream();

		// Back-pressure: receiver holds while short streams keep producing results.
		hold_req = 1;
		gap_odds = 0;
		for (int i = 0; i < 12; i++) begin
			push_word(bad_signature());
			send_stream();
		end

		// Random part; idling stops near the end.
		while (bytes_sent < ITEMS || streams_sent < MIN_STREAMS) begin
			if (bytes_sent >= ITEMS * 9 / 10 && streams_sent >= MIN_STREAMS - 4)
				quiet = 1;
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			make_random_stream();
			send_stream();
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("zip_local_header_parser test passed");
		else
			$display("zip_local_header_parser test failed");
		$finish;
	end

endmodule
